>>> rtl/core/march_memory_test_sequencer_top_macros.svh
// ----------------------------------------------------------------------------
// March memory test sequencer: assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MARCH_MEMORY_TEST_SEQUENCER_TOP_MACROS_SVH
`define MARCH_MEMORY_TEST_SEQUENCER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTSEQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTSEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mtseq_pkg.sv
// ----------------------------------------------------------------------------
// March memory test sequencer package
// Types, element tables and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package mtseq_pkg;

   localparam int NUM_ELEMENTS = 16;
   localparam int ELEM_W       = 5;
   localparam int LEN_W        = 21;
   localparam int DATA_W       = 8;
   localparam int ERR_W        = 24;
   localparam int BASE_FIELD_W = 20;

   localparam logic [LEN_W-1:0] LEN_RESET = 21'd131072;
   localparam logic [ERR_W-1:0] ERR_MAX   = 24'hFFFFFF;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef enum logic {
      CSR_BASE   = 1'b0,
      CSR_LENGTH = 1'b1
   } csr_index_type;

   // Bit i is set when element i walks the block in descending order.
   localparam logic [NUM_ELEMENTS-1:0] EL_DESC = 16'hAA8E;

   localparam logic [DATA_W-1:0] EL_EXPECT [NUM_ELEMENTS] = '{
      8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55,
      8'hAA, 8'h55, 8'h33, 8'hCC, 8'h33, 8'h0F, 8'hF0, 8'h0F};

   localparam logic [DATA_W-1:0] EL_WRITE [NUM_ELEMENTS] = '{
      8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA,
      8'h55, 8'h33, 8'hCC, 8'h33, 8'h0F, 8'hF0, 8'h0F, 8'h00};

   typedef struct packed {
      logic [ELEM_W-1:0] element_index;
      logic [LEN_W-1:0]  offset_counter;
      logic              write_phase;
      logic              pending_read;
      logic [ERR_W-1:0]  error_count;
      logic              running;
   } state_type;

endpackage

>>> rtl/core/mtseq_step.sv
// ----------------------------------------------------------------------------
// March memory test sequencer: step logic
// Works out the memory command of one tick and the next sequencer state.
// ----------------------------------------------------------------------------
module mtseq_step #(
   parameter int ADDR_WIDTH = 20
) (
   input  mtseq_pkg::state_type           state_cur,
   input  logic [ADDR_WIDTH-1:0]          block_base,
   input  logic [mtseq_pkg::LEN_W-1:0]    block_len,
   input  mtseq_pkg::op_type              op,
   input  logic [mtseq_pkg::DATA_W-1:0]   read_data,
   output mtseq_pkg::state_type           state_nxt,
   output mtseq_pkg::cmd_type             mem_cmd,
   output logic [ADDR_WIDTH-1:0]          mem_addr,
   output logic [mtseq_pkg::DATA_W-1:0]   write_data,
   output logic                           mismatch
);

   localparam int SUM_W = (ADDR_WIDTH > mtseq_pkg::LEN_W) ? ADDR_WIDTH : mtseq_pkg::LEN_W;

   logic [3:0]                      el;
   logic [SUM_W-1:0]                idx;
   logic [SUM_W-1:0]                addr_sum;
   logic                            last_step;
   logic                            advance;
   logic [mtseq_pkg::ELEM_W-1:0]    elem_inc;

   always_comb begin
      el        = state_cur.element_index[3:0];
      idx       = mtseq_pkg::EL_DESC[el]
                ? (SUM_W'(block_len) - SUM_W'(1) - SUM_W'(state_cur.offset_counter))
                : SUM_W'(state_cur.offset_counter);
      addr_sum  = SUM_W'(block_base) + idx;
      last_step = ({1'b0, state_cur.offset_counter} + 22'd1) >= {1'b0, block_len};
      elem_inc  = state_cur.element_index + 5'd1;
      advance   = 1'b0;

      state_nxt  = state_cur;
      mem_cmd    = mtseq_pkg::CMD_NONE;
      mem_addr   = '0;
      write_data = '0;
      mismatch   = 1'b0;

      if (op == mtseq_pkg::OP_START) begin
         state_nxt         = '0;
         state_nxt.running = 1'b1;
      end else if (state_cur.running) begin
         if (block_len == '0) begin
            state_nxt.element_index  = mtseq_pkg::ELEM_W'(mtseq_pkg::NUM_ELEMENTS);
            state_nxt.offset_counter = '0;
            state_nxt.write_phase    = 1'b0;
            state_nxt.pending_read   = 1'b0;
            state_nxt.running        = 1'b0;
         end else begin
            mem_addr = addr_sum[ADDR_WIDTH-1:0];
            if (el < 4'd2) begin
               mem_cmd    = mtseq_pkg::CMD_WRITE;
               write_data = mtseq_pkg::EL_WRITE[el];
               advance    = 1'b1;
            end else if (!state_cur.write_phase) begin
               mem_cmd                = mtseq_pkg::CMD_READ;
               state_nxt.pending_read = 1'b1;
               state_nxt.write_phase  = 1'b1;
            end else begin
               if (state_cur.pending_read && read_data != mtseq_pkg::EL_EXPECT[el]) begin
                  mismatch = 1'b1;
                  if (state_cur.error_count != mtseq_pkg::ERR_MAX) begin
                     state_nxt.error_count = state_cur.error_count + 24'd1;
                  end
               end
               state_nxt.pending_read = 1'b0;
               state_nxt.write_phase  = 1'b0;
               mem_cmd                = mtseq_pkg::CMD_WRITE;
               write_data             = mtseq_pkg::EL_WRITE[el];
               advance                = 1'b1;
            end
            if (advance) begin
               if (last_step) begin
                  state_nxt.offset_counter = '0;
                  state_nxt.element_index  = elem_inc;
                  if (elem_inc[4]) begin
                     state_nxt.running = 1'b0;
                  end
               end else begin
                  state_nxt.offset_counter = state_cur.offset_counter + 21'd1;
               end
            end
         end
      end
   end

endmodule

>>> rtl/core/march_memory_test_sequencer_top.sv
// ----------------------------------------------------------------------------
// March memory test sequencer: top level
// March C- style byte memory self-test. Each accepted item is one tick and
// yields one item holding the memory command for that tick.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | tuser: op; tdata: read_data
//  rsp_    | out       | tuser: mem_cmd; tdata: address, write data, mismatch,
//          |           | error total, finished
//  csr_    | in        | index 0 base address, index 1 block length
//
// One item is accepted in every cycle unless the output stalls; its result
// is registered and appears in the next cycle. The rate is set by the single
// result register, which holds a result while the output is stalled and takes
// a new one as the held result is taken. Reset is synchronous and returns the
// sequencer to idle with default base address 0 and block length 131072.
// ----------------------------------------------------------------------------
`include "march_memory_test_sequencer_top_macros.svh"

module march_memory_test_sequencer_top #(
   parameter int ADDR_WIDTH = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic                                   req_tuser,  // op
   input  logic [7:0]                             req_tdata,  // read_data
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [1:0]                             rsp_tuser,  // mem_cmd
   // mem_addr, write_data, mismatch, error_total, finished, zero fill
   output logic [((ADDR_WIDTH+34+7)/8)*8-1:0]     rsp_tdata,
   input  logic                                   csr_we,
   input  logic                                   csr_addr,
   input  logic [20:0]                            csr_wdata
);

   localparam int RSP_TDATA_W = ((ADDR_WIDTH + 34 + 7) / 8) * 8;
   localparam int BASE_W      = (ADDR_WIDTH < mtseq_pkg::BASE_FIELD_W)
                              ? ADDR_WIDTH : mtseq_pkg::BASE_FIELD_W;

   logic [ADDR_WIDTH-1:0]              base_ff, base_in;
   logic [mtseq_pkg::LEN_W-1:0]        len_ff, len_in;
   mtseq_pkg::state_type               state_ff, state_in, state_step;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [1:0]                         rsp_user_ff, rsp_user_in;
   logic [RSP_TDATA_W-1:0]             rsp_data_ff, rsp_data_in;

   logic                               req_accept;
   mtseq_pkg::cmd_type                 step_cmd;
   logic [ADDR_WIDTH-1:0]              step_addr;
   logic [mtseq_pkg::DATA_W-1:0]       step_wdata;
   logic                               step_mismatch;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   mtseq_step #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_step (
      .state_cur  (state_ff),
      .block_base (base_ff),
      .block_len  (len_ff),
      .op         (mtseq_pkg::op_type'(req_tuser)),
      .read_data  (req_tdata),
      .state_nxt  (state_step),
      .mem_cmd    (step_cmd),
      .mem_addr   (step_addr),
      .write_data (step_wdata),
      .mismatch   (step_mismatch)
   );

   always_comb begin
      base_in = base_ff;
      len_in  = len_ff;
      if (csr_we) begin
         unique case (mtseq_pkg::csr_index_type'(csr_addr))
            mtseq_pkg::CSR_BASE: begin
               base_in = ADDR_WIDTH'(csr_wdata[BASE_W-1:0]);
            end
            mtseq_pkg::CSR_LENGTH: begin
               len_in = csr_wdata;
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         state_in     = state_step;
         rsp_valid_in = 1'b1;
         rsp_user_in  = step_cmd;
         rsp_data_in  = RSP_TDATA_W'({state_step.element_index[4],
                                      state_step.error_count,
                                      step_mismatch,
                                      step_wdata,
                                      step_addr});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         len_ff       <= mtseq_pkg::LEN_RESET;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         len_ff       <= len_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   `MTSEQ_ASSERT_NOW(a_read_pairs, 1'b1, state_ff.write_phase == state_ff.pending_read, "Write phase and outstanding read have parted.")
   `MTSEQ_ASSERT_NOW(a_done_idle, state_ff.element_index[4], !state_ff.running && state_ff.element_index[3:0] == 4'd0, "Finished sequencer is still running or past the last element.")
   `MTSEQ_ASSERT_NEXT(a_start_clears, req_accept && req_tuser == mtseq_pkg::OP_START, state_ff.running && state_ff.error_count == '0, "Start item did not restart the test.")
   `MTSEQ_ASSERT_NEXT(a_err_grows, req_accept && req_tuser == mtseq_pkg::OP_ADVANCE, state_ff.error_count >= $past(state_ff.error_count), "Error count fell on an advance item.")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// March memory test sequencer testbench
// Drives ticks into the sequencer over the request stream and checks each
// command item against an in-bench model of the march test. A short scripted
// run covers idle ticks, restarts, zero and full lengths and address wrap.
// Random phases then drive march tests with mostly correct read-back data,
// under random stalls on one or both streams.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ADDR_W          = 20;
   localparam int RSP_DATA_W      = ((ADDR_W + 34 + 7) / 8) * 8;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int LONG_HOLD       = 150;
   localparam int SETTLE_CYCLES   = 4;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_CAP      = 40;

   localparam logic [19:0] TOP_ADDRESS = 20'hFFFFF;
   localparam logic [20:0] MAX_LENGTH  = 21'h100000;
   localparam logic [20:0] BOOT_LENGTH = 21'd131072;
   localparam logic [4:0]  DONE_INDEX  = 5'd16;

   // Element 15 in the top byte, element 0 in the bottom byte.
   localparam logic [15:0]  WALK_DOWN = 16'b1010_1010_1000_1110;
   localparam logic [127:0] READ_BACKGROUNDS = {
      8'h0F, 8'hF0, 8'h0F, 8'h33, 8'hCC, 8'h33, 8'h55, 8'hAA,
      8'h55, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
   localparam logic [127:0] WRITE_BACKGROUNDS = {
      8'h00, 8'h0F, 8'hF0, 8'h0F, 8'h33, 8'hCC, 8'h33, 8'h55,
      8'hAA, 8'h55, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};

   typedef struct packed {
      mtseq_pkg::cmd_type cmd;
      logic [19:0]        addr;
      logic [7:0]         wdata;
      logic               mismatch;
      logic [23:0]        errors;
      logic               finished;
   } mem_step_type;

   typedef struct packed {
      logic              is_csr;
      logic [19:0]       base;
      logic [20:0]       length;
      mtseq_pkg::op_type op;
      logic [7:0]        rdata;
      logic              typed;
      mem_step_type      want;
   } march_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = 1'b0;
   logic [7:0]            req_tdata  = 8'd0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [1:0]            rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic                  csr_addr   = 1'b0;
   logic [20:0]           csr_wdata  = 21'd0;

   // Model of the sequencer state and its two registers.
   logic [19:0] base_reg;
   logic [20:0] length_reg;
   logic [4:0]  element;
   logic [20:0] offset;
   logic        write_next;
   logic        read_outstanding;
   logic [23:0] error_tally;
   logic        active;

   mem_step_type  expected_steps [$];
   march_row_type march_script [$];

   logic sender_eager      = 1'b0;
   logic receiver_eager    = 1'b0;
   logic long_hold_pending = 1'b0;

   int cycles          = 0;
   int failures        = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int tests_completed = 0;
   int reads_flagged   = 0;
   int long_holds      = 0;

   march_memory_test_sequencer_top #(
      .ADDR_WIDTH(ADDR_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_fault(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      failures++;
      if (failures <= REPORT_CAP)
         $display("ERROR cycle %0d: %s: got 0x%0h, expected 0x%0h", cycles, what, got, want);
   endtask

   task automatic march_tick(input mtseq_pkg::op_type op, input logic [7:0] rdata,
                             output mem_step_type step);
      logic [3:0]  el;
      logic [20:0] index;
      logic [21:0] sum;
      step = '0;
      step.cmd = mtseq_pkg::CMD_NONE;
      if (op == mtseq_pkg::OP_START) begin
         element = '0;
         offset = '0;
         write_next = 1'b0;
         read_outstanding = 1'b0;
         error_tally = '0;
         active = 1'b1;
      end else if (active) begin
         if (length_reg == '0) begin
            element = DONE_INDEX;
            offset = '0;
            write_next = 1'b0;
            read_outstanding = 1'b0;
            active = 1'b0;
         end else begin
            el = element[3:0];
            index = WALK_DOWN[el] ? length_reg - 21'd1 - offset : offset;
            sum = {2'b00, base_reg} + {1'b0, index};
            step.addr = sum[19:0];
            if (el >= 4'd2 && !write_next) begin
               step.cmd = mtseq_pkg::CMD_READ;
               read_outstanding = 1'b1;
               write_next = 1'b1;
            end else begin
               if (el >= 4'd2) begin
                  if (read_outstanding && rdata != READ_BACKGROUNDS[el*8 +: 8]) begin
                     step.mismatch = 1'b1;
                     if (error_tally != mtseq_pkg::ERR_MAX)
                        error_tally = error_tally + 24'd1;
                  end
                  read_outstanding = 1'b0;
                  write_next = 1'b0;
               end
               step.cmd = mtseq_pkg::CMD_WRITE;
               step.wdata = WRITE_BACKGROUNDS[el*8 +: 8];
               if ({1'b0, offset} + 22'd1 >= {1'b0, length_reg}) begin
                  offset = '0;
                  element = element + 5'd1;
                  if (element >= DONE_INDEX) begin
                     element = DONE_INDEX;
                     active = 1'b0;
                  end
               end else begin
                  offset = offset + 21'd1;
               end
            end
         end
      end
      step.errors = error_tally;
      step.finished = (element >= DONE_INDEX);
   endtask

   task automatic offer(input mtseq_pkg::op_type op, input logic [7:0] rdata,
                        input logic typed, input mem_step_type want);
      int           gap;
      logic         was_active;
      mem_step_type step;
      gap = sender_eager ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= rdata;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      was_active = active;
      march_tick(op, rdata, step);
      expected_steps.push_back(typed ? want : step);
      items_sent++;
      if (step.mismatch)
         reads_flagged++;
      if (was_active && !active && element == DONE_INDEX)
         tests_completed++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [19:0] base, input logic [20:0] length);
      settle();
      csr_we <= 1'b1;
      csr_addr <= mtseq_pkg::CSR_BASE;
      csr_wdata <= {1'b0, base};
      @(posedge clock);
      csr_addr <= mtseq_pkg::CSR_LENGTH;
      csr_wdata <= length;
      @(posedge clock);
      csr_we <= 1'b0;
      base_reg = base;
      length_reg = length;
   endtask

   function automatic march_row_type item_row(input mtseq_pkg::op_type op,
                                              input logic [7:0] rdata);
      march_row_type row;
      row = '0;
      row.op = op;
      row.rdata = rdata;
      return row;
   endfunction

   // Typed rows never see a flagged read, so their error total is zero.
   function automatic march_row_type typed_row(input mtseq_pkg::op_type op,
                                               input logic [7:0] rdata,
                                               input mtseq_pkg::cmd_type cmd,
                                               input logic [19:0] addr,
                                               input logic [7:0] wdata,
                                               input logic finished);
      march_row_type row;
      row = item_row(op, rdata);
      row.typed = 1'b1;
      row.want.cmd = cmd;
      row.want.addr = addr;
      row.want.wdata = wdata;
      row.want.finished = finished;
      return row;
   endfunction

   function automatic march_row_type csr_row(input logic [19:0] base,
                                             input logic [20:0] length);
      march_row_type row;
      row = item_row(mtseq_pkg::OP_ADVANCE, 8'h00);
      row.is_csr = 1'b1;
      row.base = base;
      row.length = length;
      return row;
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d items outstanding", cycles,
                  expected_steps.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      mem_step_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_steps.size() == 0) begin
            report_fault("item with nothing expected", rsp_tdata[31:0], 32'd0);
         end else begin
            want = expected_steps.pop_front();
            results_checked++;
            if (rsp_tuser != want.cmd)
               report_fault("command", 32'(rsp_tuser), 32'(want.cmd));
            if (rsp_tdata[19:0] != want.addr)
               report_fault("address", 32'(rsp_tdata[19:0]), 32'(want.addr));
            if (rsp_tdata[27:20] != want.wdata)
               report_fault("write data", 32'(rsp_tdata[27:20]), 32'(want.wdata));
            if (rsp_tdata[28] != want.mismatch)
               report_fault("mismatch flag", 32'(rsp_tdata[28]), 32'(want.mismatch));
            if (rsp_tdata[52:29] != want.errors)
               report_fault("error total", 32'(rsp_tdata[52:29]), 32'(want.errors));
            if (rsp_tdata[53] != want.finished)
               report_fault("finished flag", 32'(rsp_tdata[53]), 32'(want.finished));
         end
      end
   end

   initial begin : receiver
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            gap = LONG_HOLD;
            long_hold_pending = 1'b0;
            long_holds++;
         end else begin
            gap = receiver_eager ? 0 : $urandom_range(0, 17);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      march_row_type     row;
      int                counted;
      logic              paused;
      logic [19:0]       base;
      logic [20:0]       length;
      mtseq_pkg::op_type op;
      logic [7:0]        rdata;

      base_reg = '0;
      length_reg = BOOT_LENGTH;
      element = '0;
      offset = '0;
      write_next = 1'b0;
      read_outstanding = 1'b0;
      error_tally = '0;
      active = 1'b0;

      march_script.push_back(typed_row(mtseq_pkg::OP_ADVANCE, 8'h00, mtseq_pkg::CMD_NONE,
                                       20'd0, 8'h00, 1'b0));
      march_script.push_back(typed_row(mtseq_pkg::OP_START, 8'hAA, mtseq_pkg::CMD_NONE,
                                       20'd0, 8'h00, 1'b0));
      march_script.push_back(typed_row(mtseq_pkg::OP_ADVANCE, 8'hFF, mtseq_pkg::CMD_WRITE,
                                       20'd0, 8'h00, 1'b0));
      // Shrinking the block mid-test ends the element; the address wraps to zero.
      march_script.push_back(csr_row(TOP_ADDRESS, 21'd2));
      march_script.push_back(typed_row(mtseq_pkg::OP_ADVANCE, 8'h00, mtseq_pkg::CMD_WRITE,
                                       20'd0, 8'h00, 1'b0));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'h00));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'hFF));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'h00));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'h00));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'h00));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'h5A));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'h00));
      // A restart with a read outstanding drops the read.
      march_script.push_back(typed_row(mtseq_pkg::OP_START, 8'h00, mtseq_pkg::CMD_NONE,
                                       20'd0, 8'h00, 1'b0));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'hFF));
      march_script.push_back(csr_row(20'd0, 21'd0));
      march_script.push_back(typed_row(mtseq_pkg::OP_ADVANCE, 8'h00, mtseq_pkg::CMD_NONE,
                                       20'd0, 8'h00, 1'b1));
      march_script.push_back(typed_row(mtseq_pkg::OP_ADVANCE, 8'hFF, mtseq_pkg::CMD_NONE,
                                       20'd0, 8'h00, 1'b1));
      march_script.push_back(csr_row(TOP_ADDRESS, 21'd1));
      march_script.push_back(typed_row(mtseq_pkg::OP_START, 8'hFF, mtseq_pkg::CMD_NONE,
                                       20'd0, 8'h00, 1'b0));
      march_script.push_back(typed_row(mtseq_pkg::OP_ADVANCE, 8'h00, mtseq_pkg::CMD_WRITE,
                                       TOP_ADDRESS, 8'h00, 1'b0));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'h55));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'h00));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'h00));
      march_script.push_back(csr_row(20'h80000, MAX_LENGTH));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'h00));
      march_script.push_back(item_row(mtseq_pkg::OP_ADVANCE, 8'hAA));
      march_script.push_back(typed_row(mtseq_pkg::OP_START, 8'h0F, mtseq_pkg::CMD_NONE,
                                       20'd0, 8'h00, 1'b0));
      march_script.push_back(typed_row(mtseq_pkg::OP_ADVANCE, 8'hF0, mtseq_pkg::CMD_WRITE,
                                       20'h80000, 8'h00, 1'b0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (march_script[i]) begin
         row = march_script[i];
         if (row.is_csr)
            configure(row.base, row.length);
         else
            offer(row.op, row.rdata, row.typed, row.want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         sender_eager = (phase % 3 == 1);
         receiver_eager = (phase % 4 == 2);
         case (phase)
            0: begin base = 20'($urandom_range(0, TOP_ADDRESS)); length = 21'd3; end
            1: begin base = TOP_ADDRESS;                         length = 21'd1; end
            2: begin base = 20'd0;                               length = MAX_LENGTH; end
            3: begin base = 20'($urandom_range(0, TOP_ADDRESS)); length = 21'd6; end
            4: begin base = 20'd0;                               length = 21'd0; end
            5: begin base = TOP_ADDRESS - 20'd1;                 length = 21'd2; end
            default: begin
               base = 20'($urandom_range(0, TOP_ADDRESS));
               length = 21'($urandom_range(1, 12));
            end
         endcase
         configure(base, length);
         counted = 0;
         paused = 1'b0;
         while (counted < ITEMS_PER_PHASE) begin
            if (!active)
               op = ($urandom_range(0, 2) == 0) ? mtseq_pkg::OP_START
                                                : mtseq_pkg::OP_ADVANCE;
            else
               op = ($urandom_range(0, 149) == 0) ? mtseq_pkg::OP_START
                                                  : mtseq_pkg::OP_ADVANCE;
            // Read-back data is mostly the expected background, sometimes corrupt.
            if (active && write_next && length_reg != '0 && $urandom_range(0, 9) != 0)
               rdata = READ_BACKGROUNDS[element[3:0]*8 +: 8];
            else
               rdata = 8'($urandom_range(0, 255));
            if (active || op == mtseq_pkg::OP_START)
               counted++;
            offer(op, rdata, 1'b0, '0);
            if (phase == 2 && counted == 40)
               long_hold_pending = 1'b1;
            if (phase == 5 && counted == 100 && !paused) begin
               paused = 1'b1;
               settle();
            end
         end
      end

      settle();
      $display("Checked %0d results from %0d items; %0d march tests ran to completion.",
               results_checked, items_sent, tests_completed);
      $display("Model flagged %0d bad reads; lengths 0 to 1048576, %0d long output stall(s).",
               reads_flagged, long_holds);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
